[sv/bzps_pkg.sv]
// Shared types and constants for the bilinear zoom/pan scaler.
// No dependencies; the interfaces and the top level use this package.
package bzps_pkg;

    // Default sizes of the source store and destination range
    localparam int MAX_SRC_WIDTH_DEF    = 256;
    localparam int MAX_SRC_HEIGHT_DEF   = 256;
    localparam int MAX_DST_DIM_DEF      = 4096;
    localparam int WEIGHT_FRAC_BITS_DEF = 8;

    // Fixed field widths
    localparam int COORD_W     = 8;
    localparam int DST_W       = 12;
    localparam int PIXEL_W     = 24;
    localparam int COLOR_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DIM_REG_W   = 9;
    localparam int PAN_W       = 17;
    localparam int ZOOM_W      = 28;
    localparam int FMT_W       = 2;

    // Position arithmetic: Q17 product of the doubled centre offset and inv_zoom
    localparam int POS_FRAC = 17;
    localparam int OFS_W    = 20;
    localparam int PROD_W   = OFS_W + ZOOM_W + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_PAN_X      = 3'd2,
        REG_PAN_Y      = 3'd3,
        REG_INV_ZOOM   = 3'd4,
        REG_FORMAT     = 3'd5,
        REG_BACKGROUND = 3'd6
    } cfg_reg_t;

    typedef enum logic [FMT_W-1:0] {
        FMT_GRAY8  = 2'd0,
        FMT_GRAY16 = 2'd1,
        FMT_BGR24  = 2'd2,
        FMT_BGRA32 = 2'd3
    } pixel_fmt_t;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

endpackage

[sv/bzps_if.sv]
// Valid/ready channel interfaces of the scaler: input items, results, config writes.
// Depends on bzps_pkg for field widths.
interface bzps_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [bzps_pkg::COORD_W-1:0]        src_col;
    logic [bzps_pkg::COORD_W-1:0]        src_row;
    logic [bzps_pkg::PIXEL_W-1:0]        pixel_value;
    logic [bzps_pkg::DST_W-1:0]          dst_x;
    logic [bzps_pkg::DST_W-1:0]          dst_y;

    modport source (output valid, action, src_col, src_row, pixel_value, dst_x, dst_y,
                    input ready);
    modport sink   (input valid, action, src_col, src_row, pixel_value, dst_x, dst_y,
                    output ready);
endinterface

interface bzps_out_if;
    logic                                valid;
    logic                                ready;
    logic [bzps_pkg::COLOR_W-1:0]        out_color;
    logic                                inside_source;

    modport source (output valid, out_color, inside_source, input ready);
    modport sink   (input valid, out_color, inside_source, output ready);
endinterface

interface bzps_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bzps_pkg::CFG_INDEX_W-1:0]    index;
    logic [bzps_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/bzps_ram.sv]
// Generic RAM: one write port, two registered read ports with a shared read enable.
// No dependencies.
module bzps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule

[sv/bilinear_zoom_pan_scaler_unit.sv]
// Top level of the bilinear zoom/pan scaler: config registers, six-stage pipeline.
// Depends on bzps_pkg, the interfaces in bzps_if.sv and bzps_ram.
//
// The scaler takes one item per clock unless the output stalls it, and returns a result for
// each render it accepts; write items give no result. Stalls on the output squeeze out bubbles
// stage by stage, so items keep entering while a result waits. The rate is set by the
// pixel store, held in two copies with two read ports each, one copy per source row,
// so the four neighbours of a point are read in the same cycle. Writes go to both copies at
// the read stage, which keeps them in order with renders. The store needs no clearing
// pass after reset. Config is registered when written and is always ready.
module bilinear_zoom_pan_scaler_unit #(
    parameter int MAX_SRC_WIDTH    = bzps_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT   = bzps_pkg::MAX_SRC_HEIGHT_DEF,
    parameter int MAX_DST_DIM      = bzps_pkg::MAX_DST_DIM_DEF,
    parameter int WEIGHT_FRAC_BITS = bzps_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    bzps_in_if.sink  pix_in,
    bzps_out_if.source pix_out,
    bzps_cfg_if.sink cfg
);
    import bzps_pkg::*;

    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int DXW    = $clog2(MAX_SRC_WIDTH + 1);
    localparam int DYW    = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int IXW    = $clog2(MAX_SRC_WIDTH);
    localparam int IYW    = $clog2(MAX_SRC_HEIGHT);
    localparam int WW     = WEIGHT_FRAC_BITS + 1;
    localparam int WPW    = 2 * WW;
    localparam int CPW    = WPW + 8;
    localparam int SUMW   = CPW + 2;
    localparam logic [WW-1:0] FULL_W = WW'(1) << WEIGHT_FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF_POS = PROD_W'(1) << (POS_FRAC - 1);

    // Config registers
    logic [DIM_REG_W-1:0]  src_width_reg;
    logic [DIM_REG_W-1:0]  src_height_reg;
    logic [PAN_W-1:0]      pan_x_reg;
    logic [PAN_W-1:0]      pan_y_reg;
    logic [ZOOM_W-1:0]     inv_zoom_reg;
    logic [FMT_W-1:0]      format_reg;
    logic [COLOR_W-1:0]    background_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DIM_REG_W'(256);
            src_height_reg <= DIM_REG_W'(256);
            pan_x_reg      <= '0;
            pan_y_reg      <= '0;
            inv_zoom_reg   <= ZOOM_W'(65536);
            format_reg     <= FMT_GRAY8;
            background_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_SRC_WIDTH:  src_width_reg  <= cfg.data[DIM_REG_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg.data[DIM_REG_W-1:0];
                REG_PAN_X:      pan_x_reg      <= cfg.data[PAN_W-1:0];
                REG_PAN_Y:      pan_y_reg      <= cfg.data[PAN_W-1:0];
                REG_INV_ZOOM:   inv_zoom_reg   <= cfg.data[ZOOM_W-1:0];
                REG_FORMAT:     format_reg     <= cfg.data[FMT_W-1:0];
                REG_BACKGROUND: background_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Saturate the image size into 1..max
    logic [DXW-1:0] dim_x;
    logic [DYW-1:0] dim_y;

    always_comb
    begin
        if (src_width_reg == '0)
            dim_x = DXW'(1);
        else if (32'(src_width_reg) > MAX_SRC_WIDTH)
            dim_x = DXW'(MAX_SRC_WIDTH);
        else
            dim_x = DXW'(src_width_reg);
        if (src_height_reg == '0)
            dim_y = DYW'(1);
        else if (32'(src_height_reg) > MAX_SRC_HEIGHT)
            dim_y = DYW'(MAX_SRC_HEIGHT);
        else
            dim_y = DYW'(src_height_reg);
    end

    // Stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdyo;

    assign rdyo = !vo_reg || pix_out.ready;
    assign rdy6 = !v6_reg || rdyo;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign pix_in.ready = rdy1;

    // Stage 1: doubled centre offsets, destination and write range checks
    logic                  rend1_reg;
    logic                  dst_ok1_reg;
    logic                  wr_ok1_reg;
    logic [COORD_W-1:0]    col1_reg;
    logic [COORD_W-1:0]    row1_reg;
    logic [PIXEL_W-1:0]    pix1_reg;
    logic [OFS_W-1:0]      nx1_reg;
    logic [OFS_W-1:0]      ny1_reg;
    logic [OFS_W-1:0]      nx_next;
    logic [OFS_W-1:0]      ny_next;

    always_comb
    begin
        nx_next = ((OFS_W'(pix_in.dst_x)
                    - {{(OFS_W-PAN_W){pan_x_reg[PAN_W-1]}}, pan_x_reg}) << 1) + OFS_W'(1);
        ny_next = ((OFS_W'(pix_in.dst_y)
                    - {{(OFS_W-PAN_W){pan_y_reg[PAN_W-1]}}, pan_y_reg}) << 1) + OFS_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            rend1_reg   <= (pix_in.action == ACT_RENDER);
            dst_ok1_reg <= (32'(pix_in.dst_x) < MAX_DST_DIM) && (32'(pix_in.dst_y) < MAX_DST_DIM);
            wr_ok1_reg  <= (32'(pix_in.src_col) < MAX_SRC_WIDTH)
                        && (32'(pix_in.src_row) < MAX_SRC_HEIGHT);
            col1_reg    <= pix_in.src_col;
            row1_reg    <= pix_in.src_row;
            pix1_reg    <= pix_in.pixel_value;
            nx1_reg     <= nx_next;
            ny1_reg     <= ny_next;
        end
    end

    // Stage 2: Q17 source positions
    logic                  rend2_reg, dst_ok2_reg, wr_ok2_reg;
    logic [COORD_W-1:0]    col2_reg, row2_reg;
    logic [PIXEL_W-1:0]    pix2_reg;
    logic [PROD_W-1:0]     px2_reg, py2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            rend2_reg   <= rend1_reg;
            dst_ok2_reg <= dst_ok1_reg;
            wr_ok2_reg  <= wr_ok1_reg;
            col2_reg    <= col1_reg;
            row2_reg    <= row1_reg;
            pix2_reg    <= pix1_reg;
            px2_reg     <= PROD_W'($signed(nx1_reg) * $signed({1'b0, inv_zoom_reg}));
            py2_reg     <= PROD_W'($signed(ny1_reg) * $signed({1'b0, inv_zoom_reg}));
        end
    end

    // Stage 3: inside test, integer part and fraction weight
    logic                  rend3_reg, inside3_reg, wr_ok3_reg;
    logic [COORD_W-1:0]    col3_reg, row3_reg;
    logic [PIXEL_W-1:0]    pix3_reg;
    logic [DXW-1:0]        kx3_reg;
    logic [DYW-1:0]        ky3_reg;
    logic [WEIGHT_FRAC_BITS-1:0] w1x3_reg, w1y3_reg;
    logic [PROD_W-1:0]     sx, sy;
    logic                  in_x, in_y;

    always_comb
    begin
        in_x = !px2_reg[PROD_W-1] && (px2_reg < (PROD_W'(dim_x) << POS_FRAC));
        in_y = !py2_reg[PROD_W-1] && (py2_reg < (PROD_W'(dim_y) << POS_FRAC));
        sx   = px2_reg + HALF_POS;
        sy   = py2_reg + HALF_POS;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            rend3_reg   <= rend2_reg;
            inside3_reg <= dst_ok2_reg && in_x && in_y;
            wr_ok3_reg  <= wr_ok2_reg;
            col3_reg    <= col2_reg;
            row3_reg    <= row2_reg;
            pix3_reg    <= pix2_reg;
            kx3_reg     <= sx[POS_FRAC +: DXW];
            ky3_reg     <= sy[POS_FRAC +: DYW];
            w1x3_reg    <= sx[POS_FRAC-1 -: WEIGHT_FRAC_BITS];
            w1y3_reg    <= sy[POS_FRAC-1 -: WEIGHT_FRAC_BITS];
        end
    end

    // Stage 4: clamped neighbours, store addresses, weight products
    logic                  rend4_reg, inside4_reg, wr_ok4_reg;
    logic [AW-1:0]         waddr4_reg;
    logic [PIXEL_W-1:0]    pix4_reg;
    logic [AW-1:0]         a00_reg, a01_reg, a10_reg, a11_reg;
    logic [WPW-1:0]        w00_reg, w01_reg, w10_reg, w11_reg;
    logic [IXW-1:0]        ix0_reg, ix1_reg;
    logic [DXW-1:0]        ix0_d, ix1_d;
    logic [DYW-1:0]        iy0_d, iy1_d;
    logic [IXW-1:0]        ix0, ix1;
    logic [IYW-1:0]        iy0, iy1;
    logic [WW-1:0]         w0x, w1x, w0y, w1y;

    always_comb
    begin
        ix0_d = (kx3_reg == '0) ? '0 : kx3_reg - DXW'(1);
        if (ix0_d > dim_x - DXW'(1))
            ix0_d = dim_x - DXW'(1);
        ix1_d = (kx3_reg > dim_x - DXW'(1)) ? dim_x - DXW'(1) : kx3_reg;
        iy0_d = (ky3_reg == '0) ? '0 : ky3_reg - DYW'(1);
        if (iy0_d > dim_y - DYW'(1))
            iy0_d = dim_y - DYW'(1);
        iy1_d = (ky3_reg > dim_y - DYW'(1)) ? dim_y - DYW'(1) : ky3_reg;
        ix0 = IXW'(ix0_d);
        ix1 = IXW'(ix1_d);
        iy0 = IYW'(iy0_d);
        iy1 = IYW'(iy1_d);
        w1x = WW'(w1x3_reg);
        w1y = WW'(w1y3_reg);
        w0x = FULL_W - w1x;
        w0y = FULL_W - w1y;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            rend4_reg   <= rend3_reg;
            inside4_reg <= inside3_reg;
            wr_ok4_reg  <= wr_ok3_reg;
            waddr4_reg  <= AW'(32'(row3_reg) * MAX_SRC_WIDTH + 32'(col3_reg));
            pix4_reg    <= pix3_reg;
            a00_reg     <= AW'(32'(iy0) * MAX_SRC_WIDTH + 32'(ix0));
            a01_reg     <= AW'(32'(iy0) * MAX_SRC_WIDTH + 32'(ix1));
            a10_reg     <= AW'(32'(iy1) * MAX_SRC_WIDTH + 32'(ix0));
            a11_reg     <= AW'(32'(iy1) * MAX_SRC_WIDTH + 32'(ix1));
            w00_reg     <= w0y * w0x;
            w01_reg     <= w0y * w1x;
            w10_reg     <= w1y * w0x;
            w11_reg     <= w1y * w1x;
            ix0_reg     <= ix0;
            ix1_reg     <= ix1;
        end
    end

    // Pixel store: copy A serves the upper neighbour row, copy B the lower one
    logic                  move4;
    logic                  ram_re;
    logic                  ram_we;
    logic [PIXEL_W-1:0]    p00, p01, p10, p11;

    assign move4  = v4_reg && rdy5;
    assign ram_re = move4 && rend4_reg;
    assign ram_we = move4 && !rend4_reg && wr_ok4_reg;

    bzps_ram #(.WIDTH(PIXEL_W), .DEPTH(DEPTH)) u_ram_top (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (waddr4_reg),
        .wdata   (pix4_reg),
        .re      (ram_re),
        .raddr_a (a00_reg),
        .raddr_b (a01_reg),
        .rdata_a (p00),
        .rdata_b (p01)
    );

    bzps_ram #(.WIDTH(PIXEL_W), .DEPTH(DEPTH)) u_ram_bot (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (waddr4_reg),
        .wdata   (pix4_reg),
        .re      (ram_re),
        .raddr_a (a10_reg),
        .raddr_b (a11_reg),
        .rdata_a (p10),
        .rdata_b (p11)
    );

    // Stage 5: store data arrives; carry weights along
    logic                  inside5_reg;
    logic [WPW-1:0]        w5_reg [4];

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            inside5_reg <= inside4_reg;
            w5_reg[0]   <= w00_reg;
            w5_reg[1]   <= w01_reg;
            w5_reg[2]   <= w10_reg;
            w5_reg[3]   <= w11_reg;
        end
    end

    // Stage 6: weighted channel terms
    logic                  inside6_reg;
    logic [CPW-1:0]        term6_reg [3][4];
    logic [PIXEL_W-1:0]    pix5 [4];

    always_comb
    begin
        pix5[0] = p00;
        pix5[1] = p01;
        pix5[2] = p10;
        pix5[3] = p11;
    end

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            inside6_reg <= inside5_reg;
            for (int c = 0; c < 3; c++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    term6_reg[c][j] <= CPW'(pix5[j][8*c +: 8] * w5_reg[j]);
                end
            end
        end
    end

    // Output register: sum, drop the weight fraction, pack BGRA
    logic [COLOR_W-1:0]    color_reg;
    logic                  inside_o_reg;
    logic [SUMW-1:0]       sum_c [3];
    logic [7:0]            chan [3];
    logic [COLOR_W-1:0]    color_next;
    logic                  gray;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_c[c] = SUMW'(term6_reg[c][0]) + SUMW'(term6_reg[c][1])
                     + SUMW'(term6_reg[c][2]) + SUMW'(term6_reg[c][3]);
            chan[c]  = sum_c[c][2*WEIGHT_FRAC_BITS +: 8];
        end
        gray = (format_reg == FMT_GRAY8) || (format_reg == FMT_GRAY16);
        if (!inside6_reg)
            color_next = background_reg;
        else if (gray)
            color_next = {8'hff, chan[0], chan[0], chan[0]};
        else
            color_next = {8'hff, chan[2], chan[1], chan[0]};
    end

    always_ff @(posedge clk)
    begin
        if (rdyo)
        begin
            color_reg    <= color_next;
            inside_o_reg <= inside6_reg;
        end
    end

    assign pix_out.valid         = vo_reg;
    assign pix_out.out_color     = color_reg;
    assign pix_out.inside_source = inside_o_reg;

    // Valid bits; write items leave the pipeline at the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= pix_in.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg && rend4_reg;
            if (rdy6) v6_reg <= v5_reg;
            if (rdyo) vo_reg <= v6_reg;
        end
    end

`ifndef SYNTHESIS
    // Neighbour columns are adjacent or the same clamped column
    assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && rend4_reg && inside4_reg |->
            (ix1_reg == ix0_reg) || (ix1_reg == ix0_reg + IXW'(1)))
        else $error("neighbour columns not adjacent");

    // The four bilinear weights always cover the full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && rend4_reg |->
            (32'(w00_reg) + 32'(w01_reg) + 32'(w10_reg) + 32'(w11_reg))
                == (32'(1) << (2 * WEIGHT_FRAC_BITS)))
        else $error("weight sum off scale");

    // An interpolated result is opaque
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && pix_out.inside_source |-> pix_out.out_color[31:24] == 8'hff)
        else $error("interpolated result not opaque");

    // A held first stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !rdy2 |=> v1_reg && $stable(nx1_reg) && $stable(rend1_reg))
        else $error("stalled item lost in first stage");
`endif
endmodule
